// ----- hdl/tsd_pkg.sv -----
// Shared types and constants of the TPKT stream deframer.
package tsd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned FRAMES_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] RESERVED_ZERO   = 8'h00;
    localparam logic [LEN_W-1:0]  HDR_LEN         = 16'd4;
    localparam logic [BYTE_W-1:0] VERSION_RESET   = 8'd3;
    localparam logic [LEN_W-1:0]  MAX_FRAME_RESET = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_VERSION   = 3'd1,
        ERR_RESERVED  = 3'd2,
        ERR_TOO_SHORT = 3'd3,
        ERR_TOO_LONG  = 3'd4
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_VERSION = 2'd0,
        CFG_MAX_FRAME_BYTES  = 2'd1
    } t_cfg_idx;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        t_err              error_code;
        logic [LEN_W-1:0]  frame_length;
    } t_result;

endpackage

// ----- hdl/tsd_front.sv -----
// Front part: header collection, header checks and payload classification.
module tsd_front
    import tsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_wr,
    output t_result              o_result
);

    typedef enum logic [4:0] {
        ST_HDR0    = 5'b00001,
        ST_HDR1    = 5'b00010,
        ST_HDR2    = 5'b00100,
        ST_HDR3    = 5'b01000,
        ST_PAYLOAD = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic                r_stuck, n_stuck;
    logic [BYTE_W-1:0]   r_ver, n_ver;
    logic [BYTE_W-1:0]   r_rsv, n_rsv;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [BYTE_W-1:0]   r_exp_ver;
    logic [LEN_W-1:0]    r_max;
    logic [LEN_W-1:0]    full_len;

    assign full_len = {r_len[LEN_W-1:BYTE_W], i_data_byte};

    always_comb begin
        n_state  = r_state;
        n_stuck  = r_stuck;
        n_ver    = r_ver;
        n_rsv    = r_rsv;
        n_len    = r_len;
        n_rem    = r_rem;
        o_wr     = 1'b0;
        o_result = '{kind: KIND_PAYLOAD, payload_byte: i_data_byte, frame_end: 1'b0,
                     error_code: ERR_NONE, frame_length: r_len};
        if (i_accept && !r_stuck) begin
            case (r_state)
                ST_HDR0: begin
                    n_ver   = i_data_byte;
                    n_state = ST_HDR1;
                end
                ST_HDR1: begin
                    n_rsv   = i_data_byte;
                    n_state = ST_HDR2;
                end
                ST_HDR2: begin
                    n_len   = {i_data_byte, {BYTE_W{1'b0}}};
                    n_state = ST_HDR3;
                end
                ST_HDR3: begin
                    n_len                 = full_len;
                    o_result.frame_length = full_len;
                    o_result.payload_byte = '0;
                    if (r_ver != r_exp_ver) begin
                        o_result.error_code = ERR_VERSION;
                    end else if (r_rsv != RESERVED_ZERO) begin
                        o_result.error_code = ERR_RESERVED;
                    end else if (full_len < HDR_LEN) begin
                        o_result.error_code = ERR_TOO_SHORT;
                    end else if (full_len > r_max) begin
                        o_result.error_code = ERR_TOO_LONG;
                    end
                    if (o_result.error_code != ERR_NONE) begin
                        o_result.kind = KIND_ERROR;
                        o_wr          = 1'b1;
                        n_stuck       = 1'b1;
                        n_state       = ST_HDR0;
                    end else if (full_len == HDR_LEN) begin
                        o_result.kind      = KIND_EMPTY;
                        o_result.frame_end = 1'b1;
                        o_wr               = 1'b1;
                        n_state            = ST_HDR0;
                    end else begin
                        n_rem   = full_len - HDR_LEN;
                        n_state = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    n_rem = r_rem - 1'b1;
                    o_wr  = 1'b1;
                    if (r_rem == LEN_W'(1)) begin
                        o_result.frame_end = 1'b1;
                        n_state            = ST_HDR0;
                    end
                end
                default: begin
                    n_state = ST_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HDR0;
            r_stuck   <= 1'b0;
            r_ver     <= '0;
            r_rsv     <= '0;
            r_len     <= '0;
            r_rem     <= '0;
            r_exp_ver <= VERSION_RESET;
            r_max     <= MAX_FRAME_RESET;
        end else begin
            r_state <= n_state;
            r_stuck <= n_stuck;
            r_ver   <= n_ver;
            r_rsv   <= n_rsv;
            r_len   <= n_len;
            r_rem   <= n_rem;
            if (i_cfg_we && i_cfg_index == CFG_EXPECTED_VERSION) begin
                r_exp_ver <= i_cfg_data[BYTE_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_MAX_FRAME_BYTES) begin
                r_max <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

endmodule

// ----- hdl/tsd_queue.sv -----
// Short queue of classified items between the front and the back.
module tsd_queue
    import tsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    input  logic    i_rd,
    output t_result o_data,
    output logic    o_full,
    output logic    o_empty
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/tsd_back.sv -----
// Back part: frame counting and the output register of the result side.
module tsd_back
    import tsd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_result             i_q_data,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output t_result             o_result,
    output logic [FRAMES_W-1:0] o_frames_done
);

    logic                  r_valid;
    t_result               r_result;
    logic [FRAMES_W-1:0]   r_frames;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;

    // The output register refills in the same cycle that its item is taken.
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);
    assign n_cnt  = r_cnt + COUNT_BITS'(i_q_data.frame_end);

    assign o_empty       = !r_valid;
    assign o_result      = r_result;
    assign o_frames_done = r_frames;

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_result <= i_q_data;
            r_frames <= FRAMES_W'(n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (o_q_rd) begin
                r_valid <= 1'b1;
                r_cnt   <= n_cnt;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/tpkt_stream_deframer_top.sv -----
// Top level of the TPKT stream deframer.
// Takes one stream byte per clock while full is low and returns results in
// stream order: one per payload byte, one per empty frame, and one for the
// first header error, after which every byte is dropped until reset. An item
// is classified into a four-entry queue and then held in the output register;
// the sustained rate is one byte per clock, set by the combinational header
// and payload classifier, as long as results are popped as fast as they
// appear. Configuration writes take effect on the next clock.
module tpkt_stream_deframer_top
    import tsd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [KIND_W-1:0]    o_out_kind,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic                 o_frame_end,
    output logic [ERR_W-1:0]     o_error_code,
    output logic [LEN_W-1:0]     o_frame_length,
    output logic [FRAMES_W-1:0]  o_frames_done
);

    logic    accept;
    logic    front_wr;
    t_result front_result;
    t_result q_data;
    logic    q_empty;
    logic    q_rd;
    t_result out_result;

    assign accept = push && !full;

    tsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_wr        (front_wr),
        .o_result    (front_result)
    );

    tsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_result),
        .i_rd    (q_rd),
        .o_data  (q_data),
        .o_full  (full),
        .o_empty (q_empty)
    );

    tsd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_data),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (out_result),
        .o_frames_done (o_frames_done)
    );

    assign o_out_kind     = out_result.kind;
    assign o_payload_byte = out_result.payload_byte;
    assign o_frame_end    = out_result.frame_end;
    assign o_error_code   = out_result.error_code;
    assign o_frame_length = out_result.frame_length;

endmodule

// ----- hdl/tsd_chk.sv -----
// Port-level checks of the TPKT stream deframer and their binding.
module tsd_chk
    import tsd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input logic [KIND_W-1:0]   o_out_kind,
    input logic [BYTE_W-1:0]   o_payload_byte,
    input logic                o_frame_end,
    input logic [ERR_W-1:0]    o_error_code,
    input logic [LEN_W-1:0]    o_frame_length
);

    // An error item never closes a frame and always carries a cause.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_ERROR) |-> (o_error_code != ERR_NONE && !o_frame_end))
        else $error("error item without cause or with frame end");

    a_no_stray_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code on a non-error item");

    // An empty frame is exactly a bare header.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_EMPTY) |-> (o_frame_end && o_frame_length == HDR_LEN))
        else $error("empty-frame item malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_payload_byte) && $stable(o_out_kind)))
        else $error("waiting item changed before it was taken");

endmodule

bind tpkt_stream_deframer_top tsd_chk u_tsd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_out_kind     (o_out_kind),
    .o_payload_byte (o_payload_byte),
    .o_frame_end    (o_frame_end),
    .o_error_code   (o_error_code),
    .o_frame_length (o_frame_length)
);

// ----- sim/tpkt_stream_deframer_top_test.sv -----
// Self-checking testbench of the TPKT stream deframer top level.
module tpkt_stream_deframer_top_test;
    import tsd_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned LONG_HOLD     = 240;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Header position codes of the deframing predictor.
    localparam logic [2:0] POS_VERSION  = 3'd0;
    localparam logic [2:0] POS_RESERVED = 3'd1;
    localparam logic [2:0] POS_LEN_HI   = 3'd2;
    localparam logic [2:0] POS_LEN_LO   = 3'd3;
    localparam logic [2:0] POS_PAYLOAD  = 3'd4;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   payload;
        logic                frame_end;
        t_err                code;
        logic [LEN_W-1:0]    length;
        logic [FRAMES_W-1:0] frames;
    } t_deframe_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [KIND_W-1:0]    o_out_kind;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic                 o_frame_end;
    logic [ERR_W-1:0]     o_error_code;
    logic [LEN_W-1:0]     o_frame_length;
    logic [FRAMES_W-1:0]  o_frames_done;

    // Predictor state and its copy of the registers.
    logic [BYTE_W-1:0]   want_version = VERSION_RESET;
    logic [LEN_W-1:0]    len_limit = MAX_FRAME_RESET;
    logic [2:0]          hdr_pos = POS_VERSION;
    logic [BYTE_W-1:0]   seen_version = '0;
    logic [BYTE_W-1:0]   seen_reserved = '0;
    logic [LEN_W-1:0]    decl_len = '0;
    logic [LEN_W-1:0]    to_go = '0;
    t_err                latched_err = ERR_NONE;
    logic [FRAMES_W-1:0] frame_count = '0;

    t_deframe_result pending_results [$];

    bit          idle_on = 1'b1;
    int unsigned hold_off_req = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;

    tpkt_stream_deframer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_kind     (o_out_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_end    (o_frame_end),
        .o_error_code   (o_error_code),
        .o_frame_length (o_frame_length),
        .o_frames_done  (o_frames_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out what one accepted stream byte should produce.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_deframe_result r;
        t_err            code;
        bit              produce;
        r.kind      = KIND_PAYLOAD;
        r.payload   = '0;
        r.frame_end = 1'b0;
        r.code      = ERR_NONE;
        code        = ERR_NONE;
        produce     = 1'b0;
        if (latched_err == ERR_NONE) begin
            if (hdr_pos > POS_PAYLOAD) hdr_pos = POS_VERSION;
            case (hdr_pos)
                POS_PAYLOAD: begin
                    to_go     = to_go - 1'b1;
                    r.payload = b;
                    produce   = 1'b1;
                    if (to_go == '0) begin
                        frame_count = frame_count + 1'b1;
                        hdr_pos     = POS_VERSION;
                        r.frame_end = 1'b1;
                    end
                end
                POS_VERSION: begin
                    seen_version = b;
                    hdr_pos      = POS_RESERVED;
                end
                POS_RESERVED: begin
                    seen_reserved = b;
                    hdr_pos       = POS_LEN_HI;
                end
                POS_LEN_HI: begin
                    decl_len = {b, 8'h00};
                    hdr_pos  = POS_LEN_LO;
                end
                default: begin
                    decl_len[BYTE_W-1:0] = b;
                    if (seen_version != want_version) code = ERR_VERSION;
                    else if (seen_reserved != RESERVED_ZERO) code = ERR_RESERVED;
                    else if (decl_len < HDR_LEN) code = ERR_TOO_SHORT;
                    else if (decl_len > len_limit) code = ERR_TOO_LONG;
                    hdr_pos = POS_VERSION;
                    if (code != ERR_NONE) begin
                        latched_err = code;
                        r.kind      = KIND_ERROR;
                        r.code      = code;
                        produce     = 1'b1;
                    end else if (decl_len == HDR_LEN) begin
                        frame_count = frame_count + 1'b1;
                        r.kind      = KIND_EMPTY;
                        r.frame_end = 1'b1;
                        produce     = 1'b1;
                    end else begin
                        to_go   = decl_len - HDR_LEN;
                        hdr_pos = POS_PAYLOAD;
                    end
                end
            endcase
            r.length = decl_len;
            r.frames = frame_count;
            if (produce) pending_results.push_back(r);
        end
    endtask

    // Offers one byte, with an occasional gap first, and returns once it is taken.
    // push is left high so that a following item goes out without a bubble.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] rsv,
                               input logic [LEN_W-1:0] len);
        send_byte(ver);
        send_byte(rsv);
        send_byte(len[LEN_W-1:BYTE_W]);
        send_byte(len[BYTE_W-1:0]);
    endtask

    // A well-formed frame with random payload under the current settings.
    task automatic send_frame(input logic [LEN_W-1:0] len);
        send_header(want_version, RESERVED_ZERO, len);
        repeat (len - HDR_LEN) send_byte(BYTE_W'($urandom));
    endtask

    // Stops offering, waits for every outstanding result and lets the pipe empty.
    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit more);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_EXPECTED_VERSION) want_version = data[BYTE_W-1:0];
        else if (idx == CFG_MAX_FRAME_BYTES) len_limit = data;
        cfg_writes++;
        if (!more) i_cfg_we <= 1'b0;
    endtask

    // Mostly short frames, some empty ones, the odd long one and the odd one at the limit.
    function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] limit);
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(0, 29);
        if (limit <= HDR_LEN || roll < 3) return HDR_LEN;
        if (roll == 28 && limit <= 600) return limit;
        top = (roll == 29) ? 600 : 24;
        if (top > limit) top = limit;
        return LEN_W'($urandom_range(HDR_LEN + 1, top));
    endfunction

    task automatic test_reset_defaults();
        send_header(VERSION_RESET, RESERVED_ZERO, HDR_LEN);
        send_header(VERSION_RESET, RESERVED_ZERO, 16'd6);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(VERSION_RESET, RESERVED_ZERO, 16'd7);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h5A);
    endtask

    task automatic test_unused_index();
        settle();
        write_reg(CFG_SPARE_A, 16'hFFFF, 1'b1);
        write_reg(CFG_SPARE_B, 16'h0000, 1'b0);
        send_header(want_version, RESERVED_ZERO, HDR_LEN);
        send_frame(16'd5);
    endtask

    task automatic test_version_extremes();
        logic [BYTE_W-1:0] ver;
        for (int k = 0; k < 3; k++) begin
            ver = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : BYTE_W'($urandom);
            settle();
            write_reg(CFG_EXPECTED_VERSION, {BYTE_W'($urandom), ver}, 1'b0);
            send_frame(HDR_LEN);
            repeat (2) send_frame(pick_length(len_limit));
        end
    endtask

    task automatic test_length_limits();
        logic [LEN_W-1:0] edge_len;
        settle();
        write_reg(CFG_MAX_FRAME_BYTES, HDR_LEN, 1'b0);
        repeat (4) send_frame(HDR_LEN);
        edge_len = LEN_W'($urandom_range(5, 40));
        settle();
        write_reg(CFG_MAX_FRAME_BYTES, edge_len, 1'b0);
        send_frame(edge_len);
        send_frame(pick_length(edge_len));
        send_frame(edge_len);
        // A length whose high octet is non-zero.
        settle();
        write_reg(CFG_MAX_FRAME_BYTES, MAX_FRAME_RESET, 1'b0);
        send_frame(LEN_W'(256 + $urandom_range(0, 7)));
    endtask

    task automatic test_backpressure();
        settle();
        hold_off_req = LONG_HOLD;
        send_frame(16'd40);
        send_frame(16'd40);
        settle();
        send_frame(pick_length(len_limit));
    endtask

    task automatic test_random_stream();
        int unsigned      phase_end;
        int unsigned      roll;
        logic [LEN_W-1:0] limit;
        for (int phase = 0; phase < 4; phase++) begin
            roll = $urandom_range(0, 3);
            if (roll == 0) limit = MAX_FRAME_RESET;
            else if (roll == 1) limit = LEN_W'($urandom_range(HDR_LEN, 65535));
            else limit = LEN_W'($urandom_range(5, 200));
            settle();
            write_reg(CFG_EXPECTED_VERSION, CFG_W'($urandom), 1'b1);
            write_reg(CFG_MAX_FRAME_BYTES, limit, 1'b0);
            // One phase runs without idling on either side.
            idle_on   = (phase != 2);
            phase_end = bytes_sent + 140;
            while (bytes_sent < phase_end) send_frame(pick_length(len_limit));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        int unsigned phase_end;
        idle_on   = 1'b0;
        phase_end = bytes_sent + 120;
        while (bytes_sent < phase_end) send_frame(pick_length(len_limit));
    endtask

    // Ends the stream with one bad header; everything after it must vanish.
    task automatic test_sticky_error();
        t_err              aim;
        logic [BYTE_W-1:0] bad_ver;
        logic [BYTE_W-1:0] bad_rsv;
        logic [LEN_W-1:0]  bad_len;
        aim     = t_err'($urandom_range(ERR_VERSION, ERR_TOO_LONG));
        bad_ver = want_version;
        bad_rsv = RESERVED_ZERO;
        bad_len = LEN_W'($urandom_range(HDR_LEN, 64));
        case (aim)
            ERR_VERSION: begin
                bad_ver = want_version ^ BYTE_W'($urandom_range(1, 255));
                bad_rsv = BYTE_W'($urandom);
                bad_len = LEN_W'($urandom);
            end
            ERR_RESERVED: begin
                bad_rsv = BYTE_W'($urandom_range(1, 255));
                bad_len = LEN_W'($urandom);
            end
            ERR_TOO_SHORT: bad_len = LEN_W'($urandom_range(0, HDR_LEN - 1));
            default: begin
                settle();
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_MAX_FRAME_BYTES, LEN_W'($urandom_range(HDR_LEN, 65534)), 1'b0);
                    bad_len = LEN_W'($urandom_range(len_limit + 1, 65535));
                end else begin
                    // A limit below the header size refuses every frame.
                    write_reg(CFG_MAX_FRAME_BYTES, LEN_W'($urandom_range(0, HDR_LEN - 1)), 1'b0);
                    bad_len = LEN_W'($urandom_range(HDR_LEN, 65535));
                end
            end
        endcase
        send_header(bad_ver, bad_rsv, bad_len);
        repeat (24) send_byte(BYTE_W'($urandom));
        send_frame(16'd8);
    endtask

    initial begin : result_taker
        int unsigned stall;
        stall = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_off_req != 0) begin
                stall        = hold_off_req;
                hold_off_req = 0;
            end
            if (stall != 0) begin
                pop <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                pop   <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_deframe_result want;
        if (pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte %h end %b err %0d len %0d",
                             o_out_kind, o_payload_byte, o_frame_end, o_error_code,
                             o_frame_length);
            end else begin
                want = pending_results.pop_front();
                if (o_out_kind !== want.kind || o_payload_byte !== want.payload ||
                    o_frame_end !== want.frame_end || o_error_code !== want.code ||
                    o_frame_length !== want.length || o_frames_done !== want.frames) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d differs", results_seen);
                        $display("  expected kind %0d byte %h end %b err %0d len %0d frames %0d",
                                 want.kind, want.payload, want.frame_end, want.code,
                                 want.length, want.frames);
                        $display("  actual   kind %0d byte %h end %b err %0d len %0d frames %0d",
                                 o_out_kind, o_payload_byte, o_frame_end, o_error_code,
                                 o_frame_length, o_frames_done);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("tpkt_stream_deframer_top_test: no item moved for %0d cycles", quiet);
        $display("tpkt_stream_deframer_top_test: done, errors");
        $finish;
    end

    initial begin : run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_unused_index();
        test_version_extremes();
        test_length_limits();
        test_backpressure();
        test_random_stream();
        test_no_idle();
        test_sticky_error();
        settle();
        repeat (10) @(posedge i_clk);
        $display("tpkt_stream_deframer_top_test: %0d bytes in, %0d results, %0d frames, %0d writes",
                 bytes_sent, results_seen, frame_count, cfg_writes);
        $display("tpkt_stream_deframer_top_test: stream closed by a sticky %s header error",
                 latched_err.name());
        if (mismatches == 0)
            $display("tpkt_stream_deframer_top_test: done, clean");
        else
            $display("tpkt_stream_deframer_top_test: done, errors");
        $finish;
    end

endmodule
